// File: rtl/slir_pkg.sv
// shared types and constants for the sorted list insert/remove block
package slir_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic found;
    } dp_flags_t;

endpackage

// File: rtl/slir_if.sv
// valid/ready channel interfaces for requests and responses
interface slir_req_if;
    logic                  valid;
    logic                  ready;
    logic                  command;
    slir_pkg::value_t      value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

interface slir_rsp_if;
    logic                  valid;
    logic                  ready;
    slir_pkg::status_t     status;
    slir_pkg::count_t      count;

    modport source (output valid, output status, output count, input ready);
    modport sink (input valid, input status, input count, output ready);
endinterface

// File: rtl/slir_datapath.sv
// sorted cell chain: parallel compare, shift on insert and remove, stored count
module slir_datapath #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slir_pkg::dp_cmd_t    cmd,
    input  slir_pkg::value_t     value,
    output slir_pkg::dp_flags_t  flags,
    output logic [CNT_W-1:0]     count
);

    slir_pkg::value_t  cell_reg [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DEPTH-1:0]  lt;
    logic [DEPTH-1:0]  eq;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic in_use;
            slir_pkg::value_t cell_next;

            assign in_use = count_reg > CNT_W'(i);
            assign lt[i]  = in_use && (cell_reg[i] < value);
            assign eq[i]  = in_use && (cell_reg[i] == value);

            always_comb
            begin
                cell_next = cell_reg[i];
                if (cmd.insert_en)
                begin
                    if (!lt[i])
                    begin
                        if (i == 0)
                        begin
                            cell_next = value;
                        end
                        else if (lt[(i == 0) ? 0 : i-1])
                        begin
                            cell_next = value;
                        end
                        else
                        begin
                            cell_next = cell_reg[(i == 0) ? 0 : i-1];
                        end
                    end
                end
                else if (cmd.remove_en)
                begin
                    if (!lt[i] && (i < DEPTH-1))
                    begin
                        cell_next = cell_reg[(i < DEPTH-1) ? i+1 : i];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[i] <= cell_next;
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.remove_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign flags.full  = count_reg == CNT_W'(DEPTH);
    assign flags.empty = count_reg == '0;
    assign flags.found = |eq;
    assign count       = count_reg;

endmodule

// File: rtl/slir_ctrl.sv
// handshake controller: accepts requests, issues datapath commands, holds the response
module slir_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_command,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output slir_pkg::status_t    rsp_status,
    input  slir_pkg::dp_flags_t  flags,
    output slir_pkg::dp_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic              state_reg;
    logic              state_next;
    slir_pkg::status_t status_reg;
    slir_pkg::status_t status_next;
    logic              accept;

    assign req_ready = (state_reg == ST_IDLE) || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = state_reg == ST_HOLD;
    assign rsp_status = status_reg;

    always_comb
    begin
        cmd.insert_en = 1'b0;
        cmd.remove_en = 1'b0;
        status_next   = status_reg;
        if (accept)
        begin
            case (req_command)
                slir_pkg::CMD_INSERT:
                begin
                    if (flags.full)
                    begin
                        status_next = slir_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next   = slir_pkg::ST_DONE;
                        cmd.insert_en = 1'b1;
                    end
                end
                slir_pkg::CMD_REMOVE:
                begin
                    if (flags.empty)
                    begin
                        status_next = slir_pkg::ST_EMPTY;
                    end
                    else if (!flags.found)
                    begin
                        status_next = slir_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next   = slir_pkg::ST_DONE;
                        cmd.remove_en = 1'b1;
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (rsp_ready && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

endmodule

// File: rtl/sorted_list_insert_remove.sv
// top level of the sorted list insert/remove block
//
// keeps up to DEPTH signed 32-bit values in ascending order in a chain of
// cells that all compare against the operand and shift in the same cycle
// request channel: command (0 insert, 1 remove first equal) and value
// response channel: status (done, full, not found, empty) and the count of
// stored values after the operation
// every request produces exactly one response, in order
// the response is valid in the cycle after the request transfer
// throughput: one request per cycle; a new request is taken in the same
// cycle a pending response transfers, set by the single response register
// when the receiver stalls, the response holds and no new request is taken
// reset empties the list and clears the response valid; the stored values
// need no clearing since only cells below the count are ever compared
// the count field carries the low 5 bits of the stored count
module sorted_list_insert_remove #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    slir_req_if.sink      request,
    slir_rsp_if.source    response
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = CNT_W + slir_pkg::COUNT_W;

    slir_pkg::dp_cmd_t   cmd;
    slir_pkg::dp_flags_t flags;
    logic [CNT_W-1:0]    count;
    logic [EXT_W-1:0]    count_ext;

    slir_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (request.ready),
        .rsp_valid   (response.valid),
        .rsp_ready   (response.ready),
        .rsp_status  (response.status),
        .flags       (flags),
        .cmd         (cmd)
    );

    slir_datapath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .value (request.value),
        .flags (flags),
        .count (count)
    );

    assign count_ext      = EXT_W'(count);
    assign response.count = count_ext[slir_pkg::COUNT_W-1:0];

endmodule

// File: rtl/slir_checker.sv
// port-level checks for the sorted list block and their bind to the top level
module slir_checker #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  slir_pkg::status_t rsp_status,
    input  slir_pkg::count_t  rsp_count
);

    localparam int EXT_W = 32 + slir_pkg::COUNT_W;
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);
    localparam slir_pkg::count_t DEPTH_CNT = DEPTH_EXT[slir_pkg::COUNT_W-1:0];

    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after request transfer");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
        else $error("stalled response changed");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == slir_pkg::ST_EMPTY) |-> rsp_count == '0)
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == slir_pkg::ST_FULL) |-> rsp_count == DEPTH_CNT)
        else $error("full status with count below depth");

endmodule

bind sorted_list_insert_remove slir_checker #(.DEPTH(DEPTH)) u_slir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (response.valid),
    .rsp_ready  (response.ready),
    .rsp_status (response.status),
    .rsp_count  (response.count)
);
